// ===== rtl/kdm_pkg.sv =====
// ----------------------------------------------------------------------------
// kdm_pkg
// Shared types and constants of the keypoint disk mask raster block.
// ----------------------------------------------------------------------------
package kdm_pkg;

  localparam int NUM_KEYPOINTS = 18;

  localparam int MASK_W   = 18;
  localparam int COORD_W  = 13;
  localparam int PIX_W    = 12;
  localparam int IDX_W    = 5;
  localparam int RADIUS_W = 6;
  localparam int SIZE_W   = 13;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int SQ_W     = 2 * RADIUS_W;
  localparam int SUM_W    = SQ_W + 1;
  // Difference of a pixel and a keypoint coordinate needs one bit over the wider.
  localparam int DIST_W   = COORD_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd12;
  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [R2_W-1:0]     R2_RST     = 12'd144;

  localparam logic signed [COORD_W-1:0] MISSING_COORD = -13'sd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = 2;

  localparam logic [REG_SEL_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [R2_W-1:0]     r2;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic                      vld;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } slot_t;

  typedef struct packed {
    logic s1_v;
    logic s2_v;
    logic out_v;
  } pipe_status_t;

endpackage

// ===== rtl/kdm_if.sv =====
// ----------------------------------------------------------------------------
// kdm_in_if / kdm_out_if
// Valid/ready channels carrying keypoint writes, pixel queries and masks.
// ----------------------------------------------------------------------------
interface kdm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [kdm_pkg::IDX_W-1:0]         point_index;
  logic signed [kdm_pkg::COORD_W-1:0] point_x;
  logic signed [kdm_pkg::COORD_W-1:0] point_y;
  logic [kdm_pkg::PIX_W-1:0]         pixel_x;
  logic [kdm_pkg::PIX_W-1:0]         pixel_y;

  modport source (output valid, kind, point_index, point_x, point_y, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, kind, point_index, point_x, point_y, pixel_x, pixel_y,
                output ready);
endinterface

interface kdm_out_if;
  logic                       valid;
  logic                       ready;
  logic [kdm_pkg::MASK_W-1:0] layer_mask;
  logic [kdm_pkg::PIX_W-1:0]  out_x;
  logic [kdm_pkg::PIX_W-1:0]  out_y;

  modport source (output valid, layer_mask, out_x, out_y, input ready);
  modport sink (input valid, layer_mask, out_x, out_y, output ready);
endinterface

// ===== rtl/keypoint_disk_mask_raster.sv =====
// ----------------------------------------------------------------------------
// keypoint_disk_mask_raster
// Per-pixel mask of which stored keypoint disks cover the queried pixel.
// ----------------------------------------------------------------------------
// Items arrive on in_ch. A write item (kind 0) stores one keypoint in a slot;
// a coordinate of -1 marks the keypoint missing and clears the slot. A query
// item (kind 1) names a pixel and yields one beat on out_ch carrying the
// pixel and an 18-bit mask, bit k set when slot k's disk covers the pixel.
// Pixels outside the configured image size get an all-zero mask.
// The APB port on cfg_* sets disk radius, image width and image height.
// Throughput is one item per cycle while out_ch does not stall: all slot tests run in parallel lanes.
// A query goes through three registers (input, squared distances, result)
// and its beat is offered from the result register. Writes produce no
// beat and take effect for every query accepted after them.
// When out_ch stalls, the pipeline fills and then in_ch.ready drops; no
// beat is dropped or repeated. Reset clears all slot valid flags and loads
// radius 12 and a 640 by 480 image; nothing else needs a clearing pass.
// ----------------------------------------------------------------------------
module keypoint_disk_mask_raster #(
  parameter int NUM_KEYPOINTS = kdm_pkg::NUM_KEYPOINTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  kdm_in_if.sink                         in_ch,
  kdm_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [kdm_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [kdm_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [kdm_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  kdm_pkg::cfg_t         cfg;
  kdm_pkg::slot_t        slots [NUM_KEYPOINTS];
  kdm_pkg::pipe_status_t status;
  logic                  in_ready;
  logic                  in_accept;
  logic                  wr_en;
  logic                  q_load;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;
  assign wr_en       = in_accept && (in_ch.kind == kdm_pkg::KIND_WRITE);
  assign q_load      = in_accept && (in_ch.kind == kdm_pkg::KIND_QUERY);

  kdm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  kdm_store #(
    .NumKeypoints (NUM_KEYPOINTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_index (in_ch.point_index),
    .wr_x     (in_ch.point_x),
    .wr_y     (in_ch.point_y),
    .slots    (slots)
  );

  kdm_pipe #(
    .NumKeypoints (NUM_KEYPOINTS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .slots     (slots),
    .q_load    (q_load),
    .q_x       (in_ch.pixel_x),
    .q_y       (in_ch.pixel_y),
    .q_ready   (in_ready),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_mask  (out_ch.layer_mask),
    .res_x     (out_ch.out_x),
    .res_y     (out_ch.out_y),
    .status    (status)
  );

  // Input backpressure only ever comes from an occupied, stalled first stage.
  a_ready_low_needs_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> status.s1_v)
    else $error("in_ch.ready low with an empty first stage");

  // An accepted query always lands in the first stage.
  a_query_enters : assert property (@(posedge clk) disable iff (!rst_n)
    q_load |=> status.s1_v)
    else $error("accepted query missing from first stage");

  // A new result beat can only come from an occupied second stage.
  a_out_from_s2 : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(status.s2_v))
    else $error("result beat appeared without a second-stage item");

  // The second stage is only filled from the first.
  a_s2_from_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (status.s2_v && !$past(status.s2_v)) |-> $past(status.s1_v))
    else $error("second stage filled without a first-stage item");

endmodule

// ===== rtl/kdm_cfg.sv =====
// ----------------------------------------------------------------------------
// kdm_cfg
// APB register file: disk radius, image width and image height.
// ----------------------------------------------------------------------------
module kdm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [kdm_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [kdm_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [kdm_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output kdm_pkg::cfg_t                      cfg
);

  logic [kdm_pkg::RADIUS_W-1:0]  radius_r;
  logic [kdm_pkg::R2_W-1:0]      r2_r;
  logic [kdm_pkg::SIZE_W-1:0]    width_r;
  logic [kdm_pkg::SIZE_W-1:0]    height_r;
  logic                          wr_en;
  logic [kdm_pkg::REG_SEL_W-1:0] reg_sel;
  logic [kdm_pkg::RADIUS_W-1:0]  wr_radius;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[kdm_pkg::APB_ADDR_W-1:2];
  assign wr_radius  = cfg_pwdata[kdm_pkg::RADIUS_W-1:0];

  // The squared radius is kept beside the radius so the compare path has no multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= kdm_pkg::RADIUS_RST;
      r2_r     <= kdm_pkg::R2_RST;
      width_r  <= kdm_pkg::WIDTH_RST;
      height_r <= kdm_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        kdm_pkg::REG_RADIUS: begin
          radius_r <= wr_radius;
          r2_r     <= kdm_pkg::R2_W'(wr_radius) * kdm_pkg::R2_W'(wr_radius);
        end
        kdm_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[kdm_pkg::SIZE_W-1:0];
        kdm_pkg::REG_HEIGHT: height_r <= cfg_pwdata[kdm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kdm_pkg::REG_RADIUS: cfg_prdata = kdm_pkg::APB_DATA_W'(radius_r);
      kdm_pkg::REG_WIDTH:  cfg_prdata = kdm_pkg::APB_DATA_W'(width_r);
      kdm_pkg::REG_HEIGHT: cfg_prdata = kdm_pkg::APB_DATA_W'(height_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign cfg.radius = radius_r;
  assign cfg.r2     = r2_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

// ===== rtl/kdm_store.sv =====
// ----------------------------------------------------------------------------
// kdm_store
// Keypoint slot registers with one valid flag per slot.
// ----------------------------------------------------------------------------
module kdm_store #(
  parameter int NumKeypoints = kdm_pkg::NUM_KEYPOINTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [kdm_pkg::IDX_W-1:0]          wr_index,
  input  logic signed [kdm_pkg::COORD_W-1:0] wr_x,
  input  logic signed [kdm_pkg::COORD_W-1:0] wr_y,
  output kdm_pkg::slot_t                     slots [NumKeypoints]
);

  logic wr_present;

  assign wr_present = (wr_x != kdm_pkg::MISSING_COORD) && (wr_y != kdm_pkg::MISSING_COORD);

  // An index past the last slot matches no slot, so that write is dropped.
  for (genvar k = 0; k < NumKeypoints; k++) begin : g_slot
    logic                               vld_r;
    logic signed [kdm_pkg::COORD_W-1:0] x_r;
    logic signed [kdm_pkg::COORD_W-1:0] y_r;
    logic                               hit;

    assign hit = wr_en && (wr_index == kdm_pkg::IDX_W'(k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (hit) begin
        vld_r <= wr_present;
      end
    end

    always_ff @(posedge clk) begin
      if (hit) begin
        x_r <= wr_x;
        y_r <= wr_y;
      end
    end

    assign slots[k].vld = vld_r;
    assign slots[k].x   = x_r;
    assign slots[k].y   = y_r;
  end

endmodule

// ===== rtl/kdm_pipe.sv =====
// ----------------------------------------------------------------------------
// kdm_pipe
// Query pipeline: input register, per-slot squared distances, mask register.
// ----------------------------------------------------------------------------
module kdm_pipe #(
  parameter int NumKeypoints = kdm_pkg::NUM_KEYPOINTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kdm_pkg::cfg_t                 cfg,
  input  kdm_pkg::slot_t                slots [NumKeypoints],
  input  logic                          q_load,
  input  logic [kdm_pkg::PIX_W-1:0]     q_x,
  input  logic [kdm_pkg::PIX_W-1:0]     q_y,
  output logic                          q_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [kdm_pkg::MASK_W-1:0]    res_mask,
  output logic [kdm_pkg::PIX_W-1:0]     res_x,
  output logic [kdm_pkg::PIX_W-1:0]     res_y,
  output kdm_pkg::pipe_status_t         status
);

  localparam int NearW = kdm_pkg::RADIUS_W;

  logic                          s1_v_r, s1_v_nxt;
  logic [kdm_pkg::PIX_W-1:0]     s1_x_r, s1_y_r;
  logic                          s2_v_r, s2_v_nxt;
  logic [kdm_pkg::PIX_W-1:0]     s2_x_r, s2_y_r;
  logic                          s2_in_r;
  logic [kdm_pkg::R2_W-1:0]      s2_r2_r;
  logic                          out_v_r, out_v_nxt;
  logic [kdm_pkg::MASK_W-1:0]    out_mask_r;
  logic [kdm_pkg::PIX_W-1:0]     out_x_r, out_y_r;

  logic                          out_adv, s2_adv, s1_adv;
  logic                          s1_in_image;
  logic [NumKeypoints-1:0]       lane_hit;
  logic [kdm_pkg::MASK_W-1:0]    mask_lanes;

  assign out_adv = !out_v_r || res_ready;
  assign s2_adv  = !s2_v_r || out_adv;
  assign s1_adv  = !s1_v_r || s2_adv;
  assign q_ready = s1_adv;

  always_comb begin
    s1_v_nxt  = s1_adv ? q_load : s1_v_r;
    s2_v_nxt  = s2_adv ? s1_v_r : s2_v_r;
    out_v_nxt = out_adv ? s2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign s1_in_image = ({1'b0, s1_x_r} < cfg.width) && ({1'b0, s1_y_r} < cfg.height);

  always_ff @(posedge clk) begin
    if (s1_adv && q_load) begin
      s1_x_r <= q_x;
      s1_y_r <= q_y;
    end
    if (s2_adv && s1_v_r) begin
      s2_x_r  <= s1_x_r;
      s2_y_r  <= s1_y_r;
      s2_in_r <= s1_in_image;
      s2_r2_r <= cfg.r2;
    end
    if (out_adv && s2_v_r) begin
      out_mask_r <= s2_in_r ? mask_lanes : '0;
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
    end
  end

  // One lane per slot. The radius never exceeds 63, so any axis distance of
  // 64 or more is outside the disk and only the low six bits get squared.
  for (genvar k = 0; k < NumKeypoints; k++) begin : g_lane
    logic signed [kdm_pkg::DIST_W-1:0] dx, dy;
    logic [kdm_pkg::DIST_W-1:0]        ax, ay;
    logic                              far;
    logic [kdm_pkg::SQ_W-1:0]          sqx_r, sqy_r;
    logic                              far_r;
    logic [kdm_pkg::SUM_W-1:0]         dist2;

    assign dx  = $signed({2'b00, s1_x_r}) - $signed({slots[k].x[kdm_pkg::COORD_W-1], slots[k].x});
    assign dy  = $signed({2'b00, s1_y_r}) - $signed({slots[k].y[kdm_pkg::COORD_W-1], slots[k].y});
    assign ax  = dx[kdm_pkg::DIST_W-1] ? kdm_pkg::DIST_W'(-dx) : kdm_pkg::DIST_W'(dx);
    assign ay  = dy[kdm_pkg::DIST_W-1] ? kdm_pkg::DIST_W'(-dy) : kdm_pkg::DIST_W'(dy);
    assign far = !slots[k].vld || (|ax[kdm_pkg::DIST_W-1:NearW])
                 || (|ay[kdm_pkg::DIST_W-1:NearW]);

    always_ff @(posedge clk) begin
      if (s2_adv && s1_v_r) begin
        sqx_r <= kdm_pkg::SQ_W'(ax[NearW-1:0]) * kdm_pkg::SQ_W'(ax[NearW-1:0]);
        sqy_r <= kdm_pkg::SQ_W'(ay[NearW-1:0]) * kdm_pkg::SQ_W'(ay[NearW-1:0]);
        far_r <= far;
      end
    end

    assign dist2       = {1'b0, sqx_r} + {1'b0, sqy_r};
    assign lane_hit[k] = !far_r && (dist2 <= {1'b0, s2_r2_r});
  end

  for (genvar j = 0; j < kdm_pkg::MASK_W; j++) begin : g_mask
    if (j < NumKeypoints) begin : g_used
      assign mask_lanes[j] = lane_hit[j];
    end else begin : g_unused
      assign mask_lanes[j] = 1'b0;
    end
  end

  assign res_valid     = out_v_r;
  assign res_mask      = out_mask_r;
  assign res_x         = out_x_r;
  assign res_y         = out_y_r;
  assign status.s1_v   = s1_v_r;
  assign status.s2_v   = s2_v_r;
  assign status.out_v  = out_v_r;

endmodule
